@@ hw/rtl/runge_kutta_gill_stage_unit_top_defines.svh @@
// Assertion macros for the Runge-Kutta-Gill stage unit.
`ifndef RUNGE_KUTTA_GILL_STAGE_UNIT_TOP_DEFINES_SVH
`define RUNGE_KUTTA_GILL_STAGE_UNIT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/rkg_pkg.sv @@
// Shared types, constants and arithmetic helpers of the Runge-Kutta-Gill stage unit.
`default_nettype none

package rkg_pkg;

  localparam int DATA_W     = 32;
  localparam int MAX_STATES = 64;
  localparam int ADDR_W     = $clog2(MAX_STATES);
  localparam int INDEX_W    = 6;
  localparam int DT_W       = 31;
  localparam int FRAC       = 28;
  localparam int TM_SHIFT   = 16;
  localparam int ACC_W      = 64;
  localparam int COEF_W     = 32;
  localparam int OPA_W      = DATA_W + 1;
  localparam int MUL_W      = OPA_W + COEF_W;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [DT_W-1:0] DT_RESET = 31'd655;

  // register index taken from paddr
  localparam logic REG_DT_STEP = 1'b0;

  localparam logic [1:0] STAGE_FIRST = 2'd0;
  localparam logic [1:0] STAGE_ONE   = 2'd1;
  localparam logic [1:0] STAGE_TWO   = 2'd2;
  localparam logic [1:0] STAGE_LAST  = 2'd3;

  // Gill coefficients, 28 fraction bits
  localparam logic signed [COEF_W-1:0] K_ZERO = 32'sd0;
  localparam logic signed [COEF_W-1:0] K_ONE  = 32'sd268435456;
  localparam logic signed [COEF_W-1:0] K_HALF = 32'sd134217728;
  localparam logic signed [COEF_W-1:0] K_CX1  = 32'sd78622925;
  localparam logic signed [COEF_W-1:0] K_CX2  = 32'sd458247987;
  localparam logic signed [COEF_W-1:0] K_B1   = 32'sd157245850;
  localparam logic signed [COEF_W-1:0] K_B2   = 32'sd916495974;
  localparam logic signed [COEF_W-1:0] K_C1   = 32'sd32566682;
  localparam logic signed [COEF_W-1:0] K_C2   = -32'sd1106308506;
  localparam logic signed [COEF_W-1:0] K_D1   = 32'sd44739243;
  localparam logic signed [COEF_W-1:0] K_D2   = -32'sd89478485;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TM,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_ACC,
    ST_SAT
  } state_t;

  // product slot of the shared multiplier
  typedef enum logic [1:0] {
    SLOT_1,
    SLOT_2,
    SLOT_3
  } slot_t;

  typedef enum logic [1:0] {
    OPA_TM,
    OPA_DIFF,
    OPA_Q
  } opa_t;

  typedef struct packed {
    logic [1:0] stage;
    logic       capture;
    logic       load_mem;
    logic       mul_en;
    slot_t      mul_slot;
    logic       add_en;
    slot_t      add_slot;
    logic       out_load;
    logic       mem_we;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] value;
  } sat_t;

  // floor shift then clamp to DATA_W signed
  function automatic sat_t sat_shift(input logic signed [ACC_W-1:0] v,
                                     input int unsigned sh);
    logic signed [ACC_W-1:0] s;
    sat_t r;
    s = v >>> sh;
    if (s > SAT_MAX) begin
      r.ovf   = 1'b1;
      r.value = SAT_MAX[DATA_W-1:0];
    end else if (s < SAT_MIN) begin
      r.ovf   = 1'b1;
      r.value = SAT_MIN[DATA_W-1:0];
    end else begin
      r.ovf   = 1'b0;
      r.value = s[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] stage,
                                                    input slot_t slot);
    logic signed [COEF_W-1:0] k;
    k = K_ZERO;
    case (slot)
      SLOT_1: begin
        case (stage)
          STAGE_FIRST: k = K_HALF;
          STAGE_ONE:   k = K_CX1;
          STAGE_TWO:   k = K_CX2;
          default:     k = K_D1;
        endcase
      end
      SLOT_2: begin
        case (stage)
          STAGE_FIRST: k = K_ONE;
          STAGE_ONE:   k = K_B1;
          STAGE_TWO:   k = K_B2;
          default:     k = K_D2;
        endcase
      end
      SLOT_3: begin
        case (stage)
          STAGE_ONE: k = K_C1;
          STAGE_TWO: k = K_C2;
          default:   k = K_ZERO;
        endcase
      end
      default: k = K_ZERO;
    endcase
    return k;
  endfunction

  function automatic opa_t opa_sel(input logic [1:0] stage, input slot_t slot);
    opa_t o;
    o = OPA_TM;
    case (slot)
      SLOT_1: o = (stage inside {STAGE_ONE, STAGE_TWO}) ? OPA_DIFF : OPA_TM;
      SLOT_2: o = (stage == STAGE_LAST) ? OPA_Q : OPA_TM;
      SLOT_3: o = OPA_Q;
      default: o = OPA_TM;
    endcase
    return o;
  endfunction

  // true when the slot's product goes to the y sum
  function automatic logic to_y(input logic [1:0] stage, input slot_t slot);
    logic r;
    r = 1'b0;
    case (slot)
      SLOT_1:  r = 1'b1;
      SLOT_2:  r = (stage == STAGE_LAST);
      SLOT_3:  r = 1'b0;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rkg_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none

module rkg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rkg_ctrl.sv @@
// Sequencer of the Runge-Kutta-Gill stage unit: item steps and stage counter.
`default_nettype none

module rkg_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rkg_pkg::status_t status,
  output rkg_pkg::cmd_t         cmd
);

  rkg_pkg::state_t state, state_next;
  logic [1:0] stage, stage_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rkg_pkg::ST_IDLE;
      stage <= rkg_pkg::STAGE_FIRST;
    end else begin
      state <= state_next;
      stage <= stage_next;
    end
  end

  always_comb begin
    state_next   = state;
    stage_next   = stage;
    in_stall     = 1'b1;
    cmd          = '0;
    cmd.stage    = stage;
    cmd.mul_slot = rkg_pkg::SLOT_1;
    cmd.add_slot = rkg_pkg::SLOT_1;
    case (state)
      rkg_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = rkg_pkg::ST_TM;
        end
      end
      rkg_pkg::ST_TM: begin
        cmd.load_mem = 1'b1;
        state_next   = rkg_pkg::ST_M1;
      end
      rkg_pkg::ST_M1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_slot = rkg_pkg::SLOT_1;
        state_next   = rkg_pkg::ST_M2;
      end
      rkg_pkg::ST_M2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_slot = rkg_pkg::SLOT_2;
        cmd.add_en   = 1'b1;
        cmd.add_slot = rkg_pkg::SLOT_1;
        state_next   = rkg_pkg::ST_M3;
      end
      rkg_pkg::ST_M3: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_slot = rkg_pkg::SLOT_3;
        cmd.add_en   = 1'b1;
        cmd.add_slot = rkg_pkg::SLOT_2;
        state_next   = rkg_pkg::ST_ACC;
      end
      rkg_pkg::ST_ACC: begin
        cmd.add_en   = 1'b1;
        cmd.add_slot = rkg_pkg::SLOT_3;
        state_next   = rkg_pkg::ST_SAT;
      end
      rkg_pkg::ST_SAT: begin
        // hold here until the output register can take the word
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.mem_we   = (stage != rkg_pkg::STAGE_LAST);
          state_next   = rkg_pkg::ST_IDLE;
          if (status.last) begin
            stage_next = 2'(stage + 2'd1);
          end
        end
      end
      default: state_next = rkg_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/rkg_dpath.sv @@
// Datapath of the Runge-Kutta-Gill stage unit: shared multiplier, sums, stores, output.
`default_nettype none

module rkg_dpath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rkg_pkg::cmd_t                       cmd,
  output rkg_pkg::status_t                         status,
  input  wire logic        [rkg_pkg::DT_W-1:0]     dt_step,
  input  wire logic        [rkg_pkg::INDEX_W-1:0]  elem_index,
  input  wire logic signed [rkg_pkg::DATA_W-1:0]   deriv_value,
  input  wire logic signed [rkg_pkg::DATA_W-1:0]   state_value,
  input  wire logic                                last_elem,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [rkg_pkg::DATA_W-1:0]   new_value,
  output logic             [1:0]                   stage_index,
  output logic                                     pass_end,
  output logic                                     step_done,
  output logic                                     overflow
);

  localparam int DW = rkg_pkg::DATA_W;
  localparam int AW = rkg_pkg::ACC_W;

  logic [rkg_pkg::ADDR_W-1:0] idx_reg;
  logic [DW-1:0]              x_reg;
  logic                       last_reg;
  logic [DW-1:0]              tm_reg;
  logic [DW-1:0]              q_reg;
  logic signed [AW-1:0]       prod;
  logic signed [AW-1:0]       acc_y;
  logic signed [AW-1:0]       acc_q;
  logic                       ovf_reg;

  logic [rkg_pkg::ADDR_W-1:0] mem_addr;
  logic [DW-1:0]              y_rdata;
  logic [DW-1:0]              q_rdata;

  logic signed [rkg_pkg::OPA_W-1:0]  opa;
  logic signed [rkg_pkg::COEF_W-1:0] opb;
  logic signed [rkg_pkg::MUL_W-1:0]  mul_full;
  logic signed [rkg_pkg::OPA_W-1:0]  tm_ext;
  logic signed [rkg_pkg::OPA_W-1:0]  q_ext;
  logic [DW-1:0]                     y_src;

  rkg_pkg::sat_t tm_sat;
  rkg_pkg::sat_t y_sat;
  rkg_pkg::sat_t q_sat;

  assign mem_addr = cmd.capture ? elem_index[rkg_pkg::ADDR_W-1:0] : idx_reg;

  rkg_ram #(.WIDTH(DW), .DEPTH(rkg_pkg::MAX_STATES)) u_y_ram (
    .clk   (clk),
    .we    (cmd.mem_we),
    .re    (cmd.capture),
    .addr  (mem_addr),
    .wdata (y_sat.value),
    .rdata (y_rdata)
  );

  rkg_ram #(.WIDTH(DW), .DEPTH(rkg_pkg::MAX_STATES)) u_q_ram (
    .clk   (clk),
    .we    (cmd.mem_we),
    .re    (cmd.capture),
    .addr  (mem_addr),
    .wdata (q_sat.value),
    .rdata (q_rdata)
  );

  assign tm_ext = {tm_reg[DW-1], tm_reg};
  assign q_ext  = {q_reg[DW-1], q_reg};

  // at accept the multiplier forms dt * deriv, later the Gill products
  always_comb begin
    if (cmd.capture) begin
      opa = {deriv_value[DW-1], deriv_value};
      opb = {1'b0, dt_step};
    end else begin
      case (rkg_pkg::opa_sel(cmd.stage, cmd.mul_slot))
        rkg_pkg::OPA_TM:   opa = tm_ext;
        rkg_pkg::OPA_DIFF: opa = tm_ext - q_ext;
        rkg_pkg::OPA_Q:    opa = q_ext;
        default:           opa = tm_ext;
      endcase
      opb = rkg_pkg::coef(cmd.stage, cmd.mul_slot);
    end
  end

  assign mul_full = opa * opb;

  assign y_src  = (cmd.stage == rkg_pkg::STAGE_FIRST) ? x_reg : y_rdata;
  assign tm_sat = rkg_pkg::sat_shift(prod, rkg_pkg::TM_SHIFT);
  assign y_sat  = rkg_pkg::sat_shift(acc_y, rkg_pkg::FRAC);
  assign q_sat  = rkg_pkg::sat_shift(acc_q, rkg_pkg::FRAC);

  assign status.last     = last_reg;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_reg  <= elem_index[rkg_pkg::ADDR_W-1:0];
      x_reg    <= state_value;
      last_reg <= last_elem;
    end
    if (cmd.capture || cmd.mul_en) begin
      prod <= mul_full[AW-1:0];
    end
    if (cmd.load_mem) begin
      tm_reg  <= tm_sat.value;
      ovf_reg <= tm_sat.ovf;
      q_reg   <= q_rdata;
      acc_y   <= {{(AW-DW-rkg_pkg::FRAC){y_src[DW-1]}}, y_src, {rkg_pkg::FRAC{1'b0}}};
      acc_q   <= '0;
    end else if (cmd.add_en) begin
      if (rkg_pkg::to_y(cmd.stage, cmd.add_slot)) begin
        acc_y <= acc_y + prod;
      end else begin
        acc_q <= acc_q + prod;
      end
    end
    if (cmd.out_load) begin
      new_value   <= y_sat.value;
      stage_index <= cmd.stage;
      pass_end    <= last_reg;
      step_done   <= (cmd.stage == rkg_pkg::STAGE_LAST);
      overflow    <= ovf_reg | y_sat.ovf | q_sat.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/runge_kutta_gill_stage_unit_top.sv @@
// Top level of the Runge-Kutta-Gill stage unit: register port, sequencer and datapath.
//
// Usage: each input word carries one state element (index, derivative, initial
// state, last flag) of the current stage; each accepted word yields one result
// word with the element's new y (or final state in stage 3), the stage, and flags.
// The stage counter moves to the next stage after the word flagged last.
// Words are accepted when in_valid is high and in_stall is low.
// The single 33x32 multiplier forms dt*deriv and then three Gill products in turn,
// plus the saturate step; a word is taken only after the previous one is done.
// A new word is taken while the previous result waits in the output register.
// If out_stall holds a result, the next word stops before its final step until
// the output register frees, so nothing is lost or overwritten.
// Reset (rst, synchronous) returns the stage counter to 0, empties the output
// register and sets dt_step to 655; y and q stores are not cleared and each
// element must pass stage 0 before later stages read it.
// dt_step is written through the APB port at address 0; the user must write it only
// while the block is idle, as the block itself does not enforce it.
`default_nettype none
`include "runge_kutta_gill_stage_unit_top_defines.svh"

module runge_kutta_gill_stage_unit_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [rkg_pkg::PADDR_W-1:0]  paddr,
  input  wire logic        [rkg_pkg::PDATA_W-1:0]  pwdata,
  output logic             [rkg_pkg::PDATA_W-1:0]  prdata,
  output logic                                     pready,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [rkg_pkg::INDEX_W-1:0]  elem_index,
  input  wire logic signed [rkg_pkg::DATA_W-1:0]   deriv_value,
  input  wire logic signed [rkg_pkg::DATA_W-1:0]   state_value,
  input  wire logic                                last_elem,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [rkg_pkg::DATA_W-1:0]   new_value,
  output logic             [1:0]                   stage_index,
  output logic                                     pass_end,
  output logic                                     step_done,
  output logic                                     overflow
);

  logic [rkg_pkg::DT_W-1:0] dt_step;
  logic                     dt_sel;

  rkg_pkg::cmd_t    cmd;
  rkg_pkg::status_t status;

  assign pready = 1'b1;
  assign dt_sel = (paddr[rkg_pkg::PADDR_W-1] == rkg_pkg::REG_DT_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      dt_step <= rkg_pkg::DT_RESET;
    end else if (psel && penable && pwrite && pready && dt_sel) begin
      dt_step <= pwdata[rkg_pkg::DT_W-1:0];
    end
  end

  assign prdata = dt_sel ? {{(rkg_pkg::PDATA_W-rkg_pkg::DT_W){1'b0}}, dt_step} : '0;

  rkg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rkg_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .dt_step     (dt_step),
    .elem_index  (elem_index),
    .deriv_value (deriv_value),
    .state_value (state_value),
    .last_elem   (last_elem),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .new_value   (new_value),
    .stage_index (stage_index),
    .pass_end    (pass_end),
    .step_done   (step_done),
    .overflow    (overflow)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_NEXT(a_stage_advance, clk, rst, cmd.out_load && status.last, cmd.stage == 2'($past(cmd.stage) + 2'd1))
  `ASSERT_IMPLY(a_no_store_in_last, clk, rst, cmd.mem_we, cmd.stage != rkg_pkg::STAGE_LAST)
  `ASSERT_IMPLY(a_done_flag, clk, rst, out_valid, step_done == (stage_index == rkg_pkg::STAGE_LAST))

endmodule

`default_nettype wire

@@ test/tb_runge_kutta_gill_stage_unit_top.sv @@
// Testbench for the Runge-Kutta-Gill stage unit: random and directed words vs. a predictor.
`default_nettype none

module tb_runge_kutta_gill_stage_unit_top;

  localparam int PADDR_W    = rkg_pkg::PADDR_W;
  localparam int PDATA_W    = rkg_pkg::PDATA_W;
  localparam int DT_W       = rkg_pkg::DT_W;
  localparam int INDEX_W    = rkg_pkg::INDEX_W;
  localparam int DATA_W     = rkg_pkg::DATA_W;
  localparam int MAX_STATES = rkg_pkg::MAX_STATES;

  localparam logic [DT_W-1:0] DT_RESET    = rkg_pkg::DT_RESET;
  localparam logic            REG_DT_STEP = rkg_pkg::REG_DT_STEP;
  localparam logic [1:0]      STAGE_FIRST = rkg_pkg::STAGE_FIRST;
  localparam logic [1:0]      STAGE_ONE   = rkg_pkg::STAGE_ONE;
  localparam logic [1:0]      STAGE_TWO   = rkg_pkg::STAGE_TWO;
  localparam logic [1:0]      STAGE_LAST  = rkg_pkg::STAGE_LAST;

  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_WORDS  = 145;
  localparam int FRAC_BITS    = 28;

  // Gill coefficients with 28 fraction bits
  localparam longint G_ONE  = 268435456;
  localparam longint G_HALF = 134217728;
  localparam longint G_CX1  = 78622925;
  localparam longint G_CX2  = 458247987;
  localparam longint G_B1   = 157245850;
  localparam longint G_B2   = 916495974;
  localparam longint G_C1   = 32566682;
  localparam longint G_C2   = -1106308506;
  localparam longint G_D1   = 44739243;
  localparam longint G_D2   = -89478485;
  localparam longint Q_MAX  = 64'sd2147483647;
  localparam longint Q_MIN  = -64'sd2147483648;

  localparam logic [PADDR_W-1:0] DT_STEP_ADDR = {REG_DT_STEP, 2'b00};
  localparam logic [DT_W-1:0]    DT_MAX       = {DT_W{1'b1}};

  localparam logic [INDEX_W-1:0] DIR_IDX [5] = '{6'd0, 6'd63, 6'd1, 6'd2, 6'd3};
  localparam logic signed [DATA_W-1:0] DIR_X  [5] =
    '{32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd1, -32'sd1};
  localparam logic signed [DATA_W-1:0] DIR_DA [5] =
    '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd1};
  localparam logic signed [DATA_W-1:0] DIR_DB [5] =
    '{32'sh80000000, 32'sh7fffffff, -32'sd1, 32'sd1, 32'sd0};

  typedef struct {
    logic [INDEX_W-1:0]       idx;
    logic signed [DATA_W-1:0] deriv;
    logic signed [DATA_W-1:0] state;
    logic                     last;
  } gill_word_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               stage;
    logic                     pass_end;
    logic                     step_done;
    logic                     ovf;
  } gill_result_t;

  class gill_stage_checker;
    logic [DT_W-1:0] dt_q16;
    logic [1:0]      stage;
    longint          y_mem [MAX_STATES];
    longint          q_mem [MAX_STATES];
    bit              sat_hit;
    int              mismatches;
    gill_result_t    pending_updates [$];

    function new();
      dt_q16     = DT_RESET;
      stage      = STAGE_FIRST;
      mismatches = 0;
      foreach (y_mem[i]) begin
        y_mem[i] = 0;
        q_mem[i] = 0;
      end
    endfunction

    function void set_step(logic [DT_W-1:0] v);
      dt_q16 = v;
    endfunction

    function longint clamp32(longint v);
      if (v > Q_MAX) begin
        sat_hit = 1'b1;
        return Q_MAX;
      end
      if (v < Q_MIN) begin
        sat_hit = 1'b1;
        return Q_MIN;
      end
      return v;
    endfunction

    // accepted word: advance the element's y/q and queue the expected result
    function void predict_gill_step(gill_word_t w);
      longint tm, yv, qv, res, cx, bq, cq;
      gill_result_t r;
      sat_hit = 1'b0;
      tm = clamp32((longint'(dt_q16) * longint'(w.deriv)) >>> 16);
      yv = y_mem[w.idx];
      qv = q_mem[w.idx];
      case (stage)
        STAGE_FIRST: begin
          res = clamp32((longint'(w.state) * G_ONE + tm * G_HALF) >>> FRAC_BITS);
          y_mem[w.idx] = res;
          q_mem[w.idx] = tm;
        end
        STAGE_ONE, STAGE_TWO: begin
          cx = (stage == STAGE_ONE) ? G_CX1 : G_CX2;
          bq = (stage == STAGE_ONE) ? G_B1 : G_B2;
          cq = (stage == STAGE_ONE) ? G_C1 : G_C2;
          res = clamp32((yv * G_ONE + cx * (tm - qv)) >>> FRAC_BITS);
          qv  = clamp32((bq * tm + cq * qv) >>> FRAC_BITS);
          y_mem[w.idx] = res;
          q_mem[w.idx] = qv;
        end
        default: begin
          // final stage leaves the stores alone
          res = clamp32((yv * G_ONE + G_D1 * tm + G_D2 * qv) >>> FRAC_BITS);
        end
      endcase
      r.value     = res[DATA_W-1:0];
      r.stage     = stage;
      r.pass_end  = w.last;
      r.step_done = (stage == STAGE_LAST);
      r.ovf       = sat_hit;
      pending_updates.push_back(r);
      if (w.last)
        stage = stage + 2'd1;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch: %s", what);
    endtask

    task check_stage_result(gill_result_t got);
      gill_result_t want;
      if (pending_updates.size() == 0) begin
        report("result word with nothing pending");
        return;
      end
      want = pending_updates.pop_front();
      if (got.value !== want.value)
        report($sformatf("new_value %h, want %h", got.value, want.value));
      if (got.stage !== want.stage)
        report($sformatf("stage_index %0d, want %0d", got.stage, want.stage));
      if (got.pass_end !== want.pass_end)
        report($sformatf("pass_end %b, want %b", got.pass_end, want.pass_end));
      if (got.step_done !== want.step_done)
        report($sformatf("step_done %b, want %b", got.step_done, want.step_done));
      if (got.ovf !== want.ovf)
        report($sformatf("overflow %b, want %b (value %h)", got.ovf, want.ovf, want.value));
    endtask
  endclass

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [PADDR_W-1:0]         paddr;
  logic [PDATA_W-1:0]         pwdata;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_stall;
  logic [INDEX_W-1:0]         elem_index;
  logic signed [DATA_W-1:0]   deriv_value;
  logic signed [DATA_W-1:0]   state_value;
  logic                       last_elem;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [DATA_W-1:0]   new_value;
  logic [1:0]                 stage_index;
  logic                       pass_end;
  logic                       step_done;
  logic                       overflow;

  gill_stage_checker sb;
  int                src_idle_pct;
  int                dst_idle_pct;
  int                cycles;
  int                phase_words;
  bit                written [MAX_STATES];
  int                written_list [$];
  logic [1:0]        gen_stage;

  runge_kutta_gill_stage_unit_top dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .elem_index  (elem_index),
    .deriv_value (deriv_value),
    .state_value (state_value),
    .last_elem   (last_elem),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .new_value   (new_value),
    .stage_index (stage_index),
    .pass_end    (pass_end),
    .step_done   (step_done),
    .overflow    (overflow)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk)
    out_stall = ($urandom_range(99) < dst_idle_pct);

  always @(posedge clk) begin
    gill_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.value     = new_value;
      got.stage     = stage_index;
      got.pass_end  = pass_end;
      got.step_done = step_done;
      got.ovf       = overflow;
      sb.check_stage_result(got);
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        src_idle_pct = 32;
        dst_idle_pct = 70;
      end
      1: begin
        src_idle_pct = 70;
        dst_idle_pct = 32;
      end
      default: begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
    endcase
  endtask

  // APB write of dt_step, then read it back
  task automatic write_dt(input logic [DT_W-1:0] v);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = DT_STEP_ADDR;
    pwdata  = {1'b0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_step(v);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {1'b0, v})
      sb.report($sformatf("dt_step reads %h, want %h", prdata, {1'b0, v}));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic send_word(input gill_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    elem_index  = w.idx;
    deriv_value = w.deriv;
    state_value = w.state;
    last_elem   = w.last;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.predict_gill_step(w);
  endtask

  // later stages only touch elements that stage 0 has written
  task automatic issue(input logic [INDEX_W-1:0] idx, input logic signed [DATA_W-1:0] d,
                       input logic signed [DATA_W-1:0] x, input logic last);
    gill_word_t w;
    if (gen_stage != STAGE_FIRST && !written[idx])
      idx = INDEX_W'(written_list[$urandom_range(written_list.size() - 1)]);
    if (gen_stage == STAGE_FIRST && !written[idx]) begin
      written[idx] = 1'b1;
      written_list.push_back(int'(idx));
    end
    w.idx   = idx;
    w.deriv = d;
    w.state = x;
    w.last  = last;
    send_word(w);
    if (last)
      gen_stage = gen_stage + 2'd1;
    phase_words++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_updates.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_q16();
    logic signed [DATA_W-1:0] v;
    int k;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(4095);
      default: begin
        k = $urandom_range(8, 24);
        v = $urandom_range((1 << k) - 1);
      end
    endcase
    if ($urandom_range(1))
      v = -v;
    return v;
  endfunction

  task automatic run_random(input int quota);
    logic [INDEX_W-1:0] elem_set [16];
    int n;
    phase_words = 0;
    while (phase_words < quota) begin
      if ($urandom_range(9) < 8) begin
        // a full four-pass step over one element set
        n = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          elem_set[i] = INDEX_W'($urandom_range(MAX_STATES - 1));
        repeat (4)
          for (int i = 0; i < n; i++)
            issue(elem_set[i], rand_q16(), rand_q16(), i == n - 1);
      end else begin
        // stray fragment, last flag anywhere or nowhere
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          issue(INDEX_W'($urandom_range(MAX_STATES - 1)), rand_q16(), rand_q16(),
                $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    logic [DT_W-1:0] dt_plan [6];
    sb           = new();
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    elem_index   = '0;
    deriv_value  = '0;
    state_value  = '0;
    last_elem    = 1'b0;
    out_stall    = 1'b0;
    cycles       = 0;
    gen_stage    = STAGE_FIRST;
    foreach (written[i])
      written[i] = 1'b0;
    set_idling(0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extreme fields through all four stages at the largest step
    write_dt(DT_MAX);
    for (int s = 0; s < 4; s++)
      for (int i = 0; i < 5; i++)
        issue(DIR_IDX[i], (s % 2 == 0) ? DIR_DA[i] : DIR_DB[i], DIR_X[i], i == 4);
    drain();
    // zero step: every tm is zero
    write_dt('0);
    repeat (4)
      issue(6'd10, $urandom, $urandom, 1'b1);
    drain();

    dt_plan[0] = DT_RESET;
    dt_plan[1] = 31'd1;
    dt_plan[2] = DT_MAX;
    dt_plan[3] = DT_W'($urandom_range(1, 1 << 20));
    dt_plan[4] = 31'd65536;
    dt_plan[5] = DT_W'($urandom);
    for (int p = 0; p < 6; p++) begin
      set_idling(p / 2);
      write_dt(dt_plan[p] == '0 ? 31'd1 : dt_plan[p]);
      run_random(PHASE_WORDS);
      drain();
    end

    repeat (16) @(posedge clk);
    if (sb.mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
